FILE: rtl/core/fpcm_pkg.sv
// Package with payload types, phase encoding and event codes for the PCM signalling sequencer.
package fpcm_pkg;

  typedef enum logic [2:0] {
    PH_OFF  = 3'd0,
    PH_SIG  = 3'd1,
    PH_TEST = 3'd2,
    PH_JOIN = 3'd3,
    PH_ACT  = 3'd4
  } phase_t;

  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_STOP    = 3'd1;
  localparam logic [2:0] CMD_BREAK   = 3'd2;
  localparam logic [2:0] CMD_CODE    = 3'd3;
  localparam logic [2:0] CMD_ENABLED = 3'd4;
  localparam logic [2:0] CMD_TRACE   = 3'd5;

  localparam logic CFG_OWN_KIND    = 1'b0;
  localparam logic CFG_BREAK_THRES = 1'b1;

  localparam logic [3:0] CNT_PEER_TYPE = 4'd3;
  localparam logic [3:0] CNT_TEST      = 4'd7;
  localparam logic [3:0] CNT_RESULT    = 4'd8;
  localparam logic [3:0] CNT_JOIN      = 4'd10;
  localparam logic [3:0] CNT_MAX       = 4'd15;
  localparam logic [2:0] CODE_BITS_MAX = 3'd4;

  localparam logic [2:0] LEN_RESTART = 3'd3;
  localparam logic [2:0] LEN_TYPE    = 3'd4;
  localparam logic [2:0] LEN_RESULT  = 3'd2;
  localparam logic [2:0] LEN_TEST    = 3'd1;

  typedef struct packed {
    logic [2:0] cmd;
    logic [2:0] break_reason;
    logic [3:0] rcv_bits;
    logic [7:0] lct_errors;
  } item_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       send_valid;
    logic [3:0] tx_vector;
    logic [2:0] xmit_length;
    logic       start_test;
    logic [1:0] test_length_code;
    logic       test_loop_peer;
    logic       request_join;
    logic       link_up;
    logic [1:0] peer_kind;
    logic       restarted;
    logic       fault;
  } result_t;

endpackage

FILE: rtl/core/fddi_pcm_signalling_sequencer.sv
// Top level of the PCM signalling sequencer: event decode, state registers and output stage.
//
//   channel  direction  handshake                    payload
//   item     in         item_valid / item_ready      item (fpcm_pkg::item_t)
//   result   out        result_valid / result_ready  result (fpcm_pkg::result_t)
//   cfg      in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// One event is accepted per cycle while item_ready is high; its result is registered at the
// accepting edge, in the output register or the skid entry, by the single state update path.
// Reset is synchronous and returns the phase to off with all bit stores cleared.
// A two-entry output stage keeps events flowing while one result waits; item_ready
// falls only when both entries hold results. Configuration writes are always taken.
module fddi_pcm_signalling_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  fpcm_pkg::item_t item,
  output logic            result_valid,
  input  logic            result_ready,
  output fpcm_pkg::result_t result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [2:0]      cfg_data
);

  logic [1:0]       own_kind;
  logic [2:0]       break_threshold;
  fpcm_pkg::phase_t phase, phase_next;
  logic [3:0]       bit_count, bit_count_next;
  logic [9:0]       sent_bits, sent_bits_next;
  logic [15:0]      recv_bits, recv_bits_next;
  logic [2:0]       last_length, last_length_next;
  logic [1:0]       peer_kind, peer_kind_next;

  fpcm_pkg::result_t res_next;
  fpcm_pkg::result_t skid;
  logic              skid_valid;
  logic              item_fire;

  logic [15:0] code_recv;
  logic [3:0]  code_count;
  logic [2:0]  take;
  logic [4:0]  pos_sum;
  logic [3:0]  pos;
  logic [4:0]  count_sum;
  logic [1:0]  mine, his;
  logic        do_restart;

  assign cfg_ready  = 1'b1;
  assign item_ready = !skid_valid;
  assign item_fire  = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_kind        <= 2'd0;
      break_threshold <= 3'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fpcm_pkg::CFG_OWN_KIND:    own_kind        <= cfg_data[1:0];
        fpcm_pkg::CFG_BREAK_THRES: break_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Received code bits are packed at the current count, saturating at the top position.
  always_comb begin
    take = (last_length > fpcm_pkg::CODE_BITS_MAX) ? fpcm_pkg::CODE_BITS_MAX : last_length;
    code_recv = recv_bits;
    pos_sum = 5'd0;
    pos = 4'd0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < take) begin
        pos_sum = {1'b0, bit_count} + 5'(k);
        pos = (pos_sum > {1'b0, fpcm_pkg::CNT_MAX}) ? fpcm_pkg::CNT_MAX : pos_sum[3:0];
        code_recv[pos] = item.rcv_bits[k];
      end
    end
    count_sum = {1'b0, bit_count} + {2'b00, take};
    code_count = (count_sum > {1'b0, fpcm_pkg::CNT_MAX}) ? fpcm_pkg::CNT_MAX
                                                          : count_sum[3:0];
  end

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    sent_bits_next   = sent_bits;
    recv_bits_next   = recv_bits;
    last_length_next = last_length;
    peer_kind_next   = peer_kind;
    res_next         = '0;
    do_restart       = 1'b0;
    mine             = {sent_bits[4], sent_bits[5]};
    his              = {code_recv[4], code_recv[5]};

    unique case (item.cmd)
      fpcm_pkg::CMD_START: begin
        sent_bits_next[0] = 1'b0;
        sent_bits_next[1] = own_kind[1];
        sent_bits_next[2] = own_kind[0];
        sent_bits_next[4] = 1'b0;
        sent_bits_next[5] = 1'b0;
        sent_bits_next[6] = 1'b0;
        sent_bits_next[8] = 1'b0;
        sent_bits_next[9] = 1'b1;
        do_restart = 1'b1;
      end
      fpcm_pkg::CMD_STOP: begin
        phase_next = fpcm_pkg::PH_OFF;
      end
      fpcm_pkg::CMD_BREAK: begin
        do_restart = (item.break_reason > break_threshold) && (phase != fpcm_pkg::PH_OFF);
      end
      fpcm_pkg::CMD_CODE: begin
        if (phase == fpcm_pkg::PH_SIG) begin
          recv_bits_next = code_recv;
          bit_count_next = code_count;
          if (code_count == fpcm_pkg::CNT_PEER_TYPE) begin
            if (code_recv[0]) begin
              do_restart = 1'b1;
            end else begin
              peer_kind_next       = {code_recv[1], code_recv[2]};
              sent_bits_next[3]    = 1'b1;
              res_next.send_valid  = 1'b1;
              res_next.tx_vector   = {sent_bits[6:4], 1'b1};
              res_next.xmit_length = fpcm_pkg::LEN_TYPE;
              last_length_next     = fpcm_pkg::LEN_TYPE;
            end
          end else if (code_count == fpcm_pkg::CNT_TEST) begin
            res_next.start_test       = 1'b1;
            res_next.test_length_code = (his > mine) ? his : mine;
            res_next.test_loop_peer   = code_recv[6];
            phase_next = fpcm_pkg::PH_TEST;
          end else if (code_count == fpcm_pkg::CNT_RESULT) begin
            if (sent_bits[7] || code_recv[7]) begin
              if (!sent_bits[4] && !sent_bits[5]) begin
                sent_bits_next[5] = 1'b1;
              end
              do_restart = 1'b1;
            end else begin
              res_next.send_valid  = 1'b1;
              res_next.tx_vector   = {2'b00, sent_bits[9:8]};
              res_next.xmit_length = fpcm_pkg::LEN_RESULT;
              last_length_next     = fpcm_pkg::LEN_RESULT;
            end
          end else if (code_count == fpcm_pkg::CNT_JOIN) begin
            res_next.request_join = 1'b1;
            phase_next = fpcm_pkg::PH_JOIN;
          end else begin
            res_next.fault = 1'b1;
          end
        end else if (phase == fpcm_pkg::PH_TEST) begin
          sent_bits_next[7]    = (item.lct_errors != 8'd0);
          res_next.send_valid  = 1'b1;
          res_next.tx_vector   = {3'b000, item.lct_errors != 8'd0};
          res_next.xmit_length = fpcm_pkg::LEN_TEST;
          last_length_next     = fpcm_pkg::LEN_TEST;
          phase_next = fpcm_pkg::PH_SIG;
        end else begin
          res_next.fault = 1'b1;
        end
      end
      fpcm_pkg::CMD_ENABLED: begin
        if (phase == fpcm_pkg::PH_JOIN) begin
          phase_next = fpcm_pkg::PH_ACT;
        end else begin
          res_next.fault = 1'b1;
        end
      end
      fpcm_pkg::CMD_TRACE: begin
        if (phase == fpcm_pkg::PH_ACT) begin
          phase_next = fpcm_pkg::PH_OFF;
        end else begin
          res_next.fault = 1'b1;
        end
      end
      default: begin
        res_next.fault = 1'b1;
      end
    endcase

    if (do_restart) begin
      res_next.restarted   = (phase != fpcm_pkg::PH_OFF);
      bit_count_next       = 4'd0;
      res_next.send_valid  = 1'b1;
      res_next.tx_vector   = {1'b0, sent_bits_next[2:0]};
      res_next.xmit_length = fpcm_pkg::LEN_RESTART;
      last_length_next     = fpcm_pkg::LEN_RESTART;
      phase_next           = fpcm_pkg::PH_SIG;
    end

    res_next.phase     = phase_next;
    res_next.link_up   = (phase_next == fpcm_pkg::PH_ACT);
    res_next.peer_kind = peer_kind_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= fpcm_pkg::PH_OFF;
      bit_count   <= 4'd0;
      sent_bits   <= 10'd0;
      recv_bits   <= 16'd0;
      last_length <= 3'd0;
      peer_kind   <= 2'd0;
    end else if (item_fire) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      sent_bits   <= sent_bits_next;
      recv_bits   <= recv_bits_next;
      last_length <= last_length_next;
      peer_kind   <= peer_kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= item_fire;
      end else begin
        result_valid <= item_fire;
      end
    end else if (item_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result <= skid;
        skid   <= res_next;
      end else begin
        result <= res_next;
      end
    end else if (item_fire) begin
      skid <= res_next;
    end
  end

  // The skid entry is only filled while the output register holds a result.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> result_valid)
    else $error("skid entry holds a result while the output register is empty");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.link_up == (result.phase == fpcm_pkg::PH_ACT)))
    else $error("link_up disagrees with the reported phase");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.restarted) |->
      (result.phase == fpcm_pkg::PH_SIG && result.send_valid &&
       result.xmit_length == fpcm_pkg::LEN_RESTART))
    else $error("restart did not load the opening vector");

  // A transaction that leaves the phase off must not report a transmit vector or test start.
  assert property (@(posedge clk) disable iff (rst)
    item_fire && phase_next == fpcm_pkg::PH_OFF |-> !res_next.send_valid && !res_next.start_test)
    else $error("activity reported while the phase is off");

endmodule

FILE: dv/fddi_pcm_signalling_sequencer_tb.sv
`timescale 1ns / 100ps
// Testbench for the PCM signalling sequencer: directed and random event streams checked by a predictor.
module fddi_pcm_signalling_sequencer_tb;

  localparam int CLK_HALF = 5;
  localparam int RST_CYCLES = 10;
  localparam int MAX_GAP = 14;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 3;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] CMD_BAD_6 = 3'd6;
  localparam logic [2:0] CMD_BAD_7 = 3'd7;

  logic              clk;
  logic              rst = 1'b1;
  logic              item_valid;
  logic              item_ready;
  fpcm_pkg::item_t   item;
  logic              result_valid;
  logic              result_ready;
  fpcm_pkg::result_t result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [2:0]        cfg_data;

  bit tx_fast = 1'b0;
  bit rx_fast = 1'b0;
  bit rx_hold_req = 1'b0;
  int err_cnt = 0;

  fpcm_pkg::result_t expected_results[$];

  logic [1:0]       cfg_own_kind = 2'd0;
  logic [2:0]       cfg_brk_thr = 3'd1;
  fpcm_pkg::phase_t pcm_phase = fpcm_pkg::PH_OFF;
  logic [3:0]       pcm_bit_cnt = 4'd0;
  logic [9:0]       pcm_tx_bits = 10'd0;
  logic [15:0]      pcm_rx_bits = 16'd0;
  logic [2:0]       pcm_last_len = 3'd0;
  logic [1:0]       pcm_peer_kind = 2'd0;

  fddi_pcm_signalling_sequencer u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void load_vector(inout fpcm_pkg::result_t r, input logic [3:0] vec,
                                      input logic [2:0] len);
    r.send_valid = 1'b1;
    r.tx_vector = vec;
    r.xmit_length = len;
    pcm_last_len = len;
  endfunction

  function automatic void restart_signalling(inout fpcm_pkg::result_t r);
    if (pcm_phase != fpcm_pkg::PH_OFF) begin
      r.restarted = 1'b1;
    end
    pcm_bit_cnt = 4'd0;
    load_vector(r, {1'b0, pcm_tx_bits[2:0]}, fpcm_pkg::LEN_RESTART);
    pcm_phase = fpcm_pkg::PH_SIG;
  endfunction

  function automatic fpcm_pkg::result_t next_pcm_result(input fpcm_pkg::item_t ev);
    fpcm_pkg::result_t r;
    logic [3:0] n;
    logic [1:0] mine;
    logic [1:0] his;
    r = '0;
    unique case (ev.cmd)
      fpcm_pkg::CMD_START: begin
        pcm_tx_bits[0] = 1'b0;
        pcm_tx_bits[1] = cfg_own_kind[1];
        pcm_tx_bits[2] = cfg_own_kind[0];
        pcm_tx_bits[6:4] = 3'b000;
        pcm_tx_bits[9:8] = 2'b10;
        restart_signalling(r);
      end
      fpcm_pkg::CMD_STOP: begin
        pcm_phase = fpcm_pkg::PH_OFF;
      end
      fpcm_pkg::CMD_BREAK: begin
        if (ev.break_reason > cfg_brk_thr && pcm_phase != fpcm_pkg::PH_OFF) begin
          restart_signalling(r);
        end
      end
      fpcm_pkg::CMD_CODE: begin
        if (pcm_phase == fpcm_pkg::PH_SIG) begin
          n = pcm_bit_cnt;
          for (int k = 0; k < 4; k++) begin
            if (k < pcm_last_len) begin
              pcm_rx_bits[n] = ev.rcv_bits[k];
              if (n < fpcm_pkg::CNT_MAX) begin
                n = n + 4'd1;
              end
            end
          end
          pcm_bit_cnt = n;
          unique case (n)
            fpcm_pkg::CNT_PEER_TYPE: begin
              if (pcm_rx_bits[0]) begin
                restart_signalling(r);
              end else begin
                pcm_peer_kind = {pcm_rx_bits[1], pcm_rx_bits[2]};
                pcm_tx_bits[3] = 1'b1;
                load_vector(r, pcm_tx_bits[6:3], fpcm_pkg::LEN_TYPE);
              end
            end
            fpcm_pkg::CNT_TEST: begin
              mine = {pcm_tx_bits[4], pcm_tx_bits[5]};
              his = {pcm_rx_bits[4], pcm_rx_bits[5]};
              r.start_test = 1'b1;
              r.test_length_code = (his > mine) ? his : mine;
              r.test_loop_peer = pcm_rx_bits[6];
              pcm_phase = fpcm_pkg::PH_TEST;
            end
            fpcm_pkg::CNT_RESULT: begin
              if (pcm_tx_bits[7] || pcm_rx_bits[7]) begin
                if (!pcm_tx_bits[4] && !pcm_tx_bits[5]) begin
                  pcm_tx_bits[5] = 1'b1;
                end
                restart_signalling(r);
              end else begin
                load_vector(r, {2'b00, pcm_tx_bits[9:8]}, fpcm_pkg::LEN_RESULT);
              end
            end
            fpcm_pkg::CNT_JOIN: begin
              r.request_join = 1'b1;
              pcm_phase = fpcm_pkg::PH_JOIN;
            end
            default: begin
              r.fault = 1'b1;
            end
          endcase
        end else if (pcm_phase == fpcm_pkg::PH_TEST) begin
          pcm_tx_bits[7] = (ev.lct_errors != 8'd0);
          load_vector(r, {3'b000, pcm_tx_bits[7]}, fpcm_pkg::LEN_TEST);
          pcm_phase = fpcm_pkg::PH_SIG;
        end else begin
          r.fault = 1'b1;
        end
      end
      fpcm_pkg::CMD_ENABLED: begin
        if (pcm_phase == fpcm_pkg::PH_JOIN) begin
          pcm_phase = fpcm_pkg::PH_ACT;
        end else begin
          r.fault = 1'b1;
        end
      end
      fpcm_pkg::CMD_TRACE: begin
        if (pcm_phase == fpcm_pkg::PH_ACT) begin
          pcm_phase = fpcm_pkg::PH_OFF;
        end else begin
          r.fault = 1'b1;
        end
      end
      default: begin
        r.fault = 1'b1;
      end
    endcase
    r.phase = pcm_phase;
    r.link_up = (pcm_phase == fpcm_pkg::PH_ACT);
    r.peer_kind = pcm_peer_kind;
    return r;
  endfunction

  function automatic fpcm_pkg::item_t make_event(input logic [2:0] cmd,
                                                 input logic [2:0] reason,
                                                 input logic [3:0] rcv,
                                                 input logic [7:0] errs);
    fpcm_pkg::item_t ev;
    ev.cmd = cmd;
    ev.break_reason = reason;
    ev.rcv_bits = rcv;
    ev.lct_errors = errs;
    return ev;
  endfunction

  // Mostly the event that moves the exchange forward, with random content, plus noise.
  function automatic fpcm_pkg::item_t walk_event();
    fpcm_pkg::item_t ev;
    logic [31:0] roll;
    int unsigned pick;
    roll = $urandom;
    ev = roll[$bits(fpcm_pkg::item_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      return ev;
    end
    if (pick < 16) begin
      ev.cmd = fpcm_pkg::CMD_BREAK;
      return ev;
    end
    unique case (pcm_phase)
      fpcm_pkg::PH_OFF: begin
        ev.cmd = fpcm_pkg::CMD_START;
      end
      fpcm_pkg::PH_SIG, fpcm_pkg::PH_TEST: begin
        ev.cmd = fpcm_pkg::CMD_CODE;
        if ($urandom_range(0, 3) != 0) begin
          ev.rcv_bits[0] = 1'b0;
        end
        if ($urandom_range(0, 1) == 0) begin
          ev.lct_errors = 8'd0;
        end
      end
      fpcm_pkg::PH_JOIN: begin
        ev.cmd = fpcm_pkg::CMD_ENABLED;
      end
      default: begin
        ev.cmd = ($urandom_range(0, 3) == 0) ? fpcm_pkg::CMD_STOP : fpcm_pkg::CMD_TRACE;
      end
    endcase
    return ev;
  endfunction

  task automatic send_event(input fpcm_pkg::item_t ev);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= ev;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    expected_results.push_back(next_pcm_result(ev));
  endtask

  task automatic drop_item();
    @(negedge clk);
    item_valid <= 1'b0;
  endtask

  task automatic settle_results();
    int waited;
    waited = 0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      err_cnt++;
      expected_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [2:0] val);
    drop_item();
    settle_results();
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == fpcm_pkg::CFG_OWN_KIND) begin
      cfg_own_kind = val[1:0];
    end else begin
      cfg_brk_thr = val;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    fpcm_pkg::result_t exp_r;
    result_ready = 1'b0;
    forever begin
      stall = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
      if (rx_hold_req) begin
        stall = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      @(negedge clk);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      if (expected_results.size() == 0) begin
        $display("%0t: result transaction with nothing expected, actual %h", $time, result);
        err_cnt++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result !== exp_r) begin
          $display("%0t: result mismatch, expected %h, actual %h", $time, exp_r, result);
          err_cnt++;
        end
      end
    end
  end

  task automatic test_off_phase_events();
    send_event(make_event(fpcm_pkg::CMD_CODE, 3'd0, 4'hF, 8'hFF));
    send_event(make_event(fpcm_pkg::CMD_ENABLED, 3'd7, 4'h0, 8'h00));
    send_event(make_event(fpcm_pkg::CMD_TRACE, 3'd0, 4'hF, 8'h00));
    send_event(make_event(fpcm_pkg::CMD_BREAK, 3'd7, 4'h0, 8'hFF));
    send_event(make_event(CMD_BAD_6, 3'd7, 4'hF, 8'hFF));
    send_event(make_event(CMD_BAD_7, 3'd0, 4'h0, 8'h00));
    send_event(make_event(fpcm_pkg::CMD_STOP, 3'd7, 4'hF, 8'hFF));
  endtask

  task automatic test_signalling_exchange();
    write_reg(fpcm_pkg::CFG_OWN_KIND, 3'd3);
    write_reg(fpcm_pkg::CFG_BREAK_THRES, 3'd1);
    send_event(make_event(fpcm_pkg::CMD_START, 3'd0, 4'h0, 8'h00));
    send_event(make_event(fpcm_pkg::CMD_CODE, 3'd0, 4'b0110, 8'h00));
    send_event(make_event(fpcm_pkg::CMD_CODE, 3'd0, 4'b1111, 8'h00));
    send_event(make_event(fpcm_pkg::CMD_CODE, 3'd0, 4'b0000, 8'h00));
    send_event(make_event(fpcm_pkg::CMD_CODE, 3'd0, 4'b0000, 8'h00));
    send_event(make_event(fpcm_pkg::CMD_CODE, 3'd0, 4'b0011, 8'h00));
    send_event(make_event(fpcm_pkg::CMD_ENABLED, 3'd0, 4'h0, 8'h00));
    send_event(make_event(fpcm_pkg::CMD_TRACE, 3'd0, 4'h0, 8'h00));
    // Escape flag in the first received group restarts signalling.
    send_event(make_event(fpcm_pkg::CMD_START, 3'd0, 4'h0, 8'h00));
    send_event(make_event(fpcm_pkg::CMD_CODE, 3'd0, 4'b0001, 8'h00));
    // A test with errors restarts and forces a medium test next time.
    send_event(make_event(fpcm_pkg::CMD_CODE, 3'd0, 4'b1110, 8'h00));
    send_event(make_event(fpcm_pkg::CMD_CODE, 3'd0, 4'b0000, 8'h00));
    send_event(make_event(fpcm_pkg::CMD_CODE, 3'd0, 4'h0, 8'hFF));
    send_event(make_event(fpcm_pkg::CMD_CODE, 3'd0, 4'b0000, 8'h00));
    send_event(make_event(fpcm_pkg::CMD_BREAK, 3'd1, 4'h0, 8'h00));
    send_event(make_event(fpcm_pkg::CMD_BREAK, 3'd7, 4'h0, 8'h00));
    send_event(make_event(fpcm_pkg::CMD_START, 3'd0, 4'h0, 8'h00));
    send_event(make_event(fpcm_pkg::CMD_STOP, 3'd0, 4'h0, 8'h00));
  endtask

  task automatic test_register_extremes();
    logic [1:0] kinds [4];
    logic [2:0] thresholds [4];
    kinds = '{2'd0, 2'd3, 2'd0, 2'd3};
    thresholds = '{3'd0, 3'd7, 3'd7, 3'd0};
    for (int i = 0; i < 4; i++) begin
      write_reg(fpcm_pkg::CFG_OWN_KIND, {1'b0, kinds[i]});
      write_reg(fpcm_pkg::CFG_BREAK_THRES, thresholds[i]);
      repeat (60) send_event(walk_event());
    end
  endtask

  task automatic test_output_backpressure();
    rx_hold_req = 1'b1;
    tx_fast = 1'b1;
    repeat (24) send_event(walk_event());
    tx_fast = 1'b0;
  endtask

  task automatic test_random_walk();
    logic [31:0] roll;
    for (int i = 0; i < 1100; i++) begin
      if (i % 150 == 0) begin
        roll = $urandom;
        write_reg(fpcm_pkg::CFG_OWN_KIND, {1'b0, roll[1:0]});
        write_reg(fpcm_pkg::CFG_BREAK_THRES, roll[4:2]);
      end
      if (i % 100 == 0) begin
        tx_fast = ($urandom_range(0, 3) == 0);
        rx_fast = ($urandom_range(0, 3) == 0);
      end
      send_event(walk_event());
    end
    tx_fast = 1'b0;
    rx_fast = 1'b0;
  endtask

  initial begin
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = fpcm_pkg::CFG_OWN_KIND;
    cfg_data = 3'd0;
    repeat (RST_CYCLES) @(negedge clk);
    rst <= 1'b0;
    test_off_phase_events();
    test_signalling_exchange();
    test_register_extremes();
    test_output_backpressure();
    test_random_walk();
    drop_item();
    settle_results();
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
